// ===== hw/rtl/pspa_pkg.sv =====
`timescale 1ns / 1ps
package pspa_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int MASK_W      = 8;
    localparam int QLEN_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int BUSY_W      = $clog2(NUM_SLOTS + 1);
    localparam int SIDX_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [1:0] {
        OP_ACQUIRE  = 2'd0,
        OP_RELEASE  = 2'd1,
        OP_TICK     = 2'd2,
        OP_SHUTDOWN = 2'd3
    } pspa_op_t;

    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_TIMED_OUT = 3'd2,
        ST_REFUSED   = 3'd3,
        ST_FULL      = 3'd4,
        ST_RELEASED  = 3'd5,
        ST_BAD_REL   = 3'd6
    } pspa_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } pspa_state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  priority_req;
        logic [7:0]  requester;
        logic [3:0]  slot;
        logic [15:0] timeout_ticks;
    } pspa_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] requester_out;
        logic [3:0] slot_out;
        logic [3:0] busy_count;
        logic [4:0] waiting_count;
        logic       last;
    } pspa_out_t;

    typedef struct packed {
        logic [3:0]  prio;
        logic [7:0]  req;
        logic [31:0] deadline;
    } pspa_waiter_t;

    // Hand-off from the front queue to the engine
    typedef struct packed {
        logic     valid;
        pspa_in_t item;
    } pspa_cmd_t;

endpackage

// ===== hw/rtl/pspa_front.sv =====
`timescale 1ns / 1ps
module pspa_front import pspa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  pspa_in_t  s_data,
    output pspa_cmd_t cmd,
    input  logic      cmd_pop
);

    pspa_in_t   buf_reg [FIFO_DEPTH];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign s_ready = (cnt_reg < 2'(FIFO_DEPTH));
    assign push    = s_valid && s_ready;

    // Present the oldest command
    assign cmd.valid = (cnt_reg != 2'd0);
    assign cmd.item  = buf_reg[rd_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_next  = push ? ~wr_reg : wr_reg;
        rd_next  = cmd_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= s_data;
        end
    end

endmodule

// ===== hw/rtl/pspa_engine.sv =====
`timescale 1ns / 1ps
module pspa_engine import pspa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_wdata,
    input  pspa_cmd_t         cmd,
    output logic              cmd_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output pspa_out_t         m_data
);

    pspa_state_t          state_reg, state_next;
    logic [QLEN_W-1:0]    scan_reg, scan_next;
    logic [QLEN_W-1:0]    len_reg, len_next;
    logic [NUM_SLOTS-1:0] busy_reg, busy_next;
    logic [BUSY_W-1:0]    bcnt_reg, bcnt_next;
    logic [31:0]          tick_reg, tick_next;
    logic                 shut_reg, shut_next;
    logic [MASK_W-1:0]    mask_reg, mask_next;
    logic                 pend_valid_reg, pend_valid_next;
    pspa_out_t            pend_reg, pend_next;
    logic                 m_valid_reg, m_valid_next;
    pspa_out_t            m_data_reg, m_data_next;
    pspa_waiter_t         wq_reg [QUEUE_DEPTH];
    pspa_waiter_t         wq_next [QUEUE_DEPTH];

    logic                 out_ok;
    logic                 emit;
    pspa_out_t            emit_d;
    logic                 ins_en, rem_en;
    logic [QLEN_W-1:0]    ins_pos, rem_pos;
    pspa_waiter_t         ins_w;
    logic                 free_found;
    logic [SIDX_W-1:0]    free_idx;
    logic                 slot_ok, slot_live;
    pspa_waiter_t         scan_w;
    logic [31:0]          age;
    pspa_in_t             it;

    assign it      = cmd.item;
    assign out_ok  = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign scan_w  = wq_reg[scan_reg[QIDX_W-1:0]];
    assign age     = tick_reg - scan_w.deadline;

    // Lowest free valid slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (i < MASK_W && !busy_reg[i] && mask_reg[i % MASK_W]) begin
                free_found = 1'b1;
                free_idx   = SIDX_W'(i);
            end
        end
    end

    // Classify the release slot
    always_comb begin
        slot_ok   = (32'(it.slot) < NUM_SLOTS) && busy_reg[it.slot[SIDX_W-1:0]];
        slot_live = (32'(it.slot) < MASK_W) && mask_reg[it.slot[$clog2(MASK_W)-1:0]];
    end

    // Insert position: behind every waiter of equal or better priority
    always_comb begin
        ins_pos = '0;
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            if (j < int'(len_reg) && wq_reg[j].prio <= it.priority_req) begin
                ins_pos = ins_pos + QLEN_W'(1);
            end
        end
        ins_w.prio     = it.priority_req;
        ins_w.req      = it.requester;
        ins_w.deadline = tick_reg + {16'd0, it.timeout_ticks};
    end

    // Sequence the operations
    always_comb begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        len_next        = len_reg;
        busy_next       = busy_reg;
        bcnt_next       = bcnt_reg;
        tick_next       = tick_reg;
        shut_next       = shut_reg;
        mask_next       = cfg_we ? cfg_wdata : mask_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cmd_pop         = 1'b0;
        emit            = 1'b0;
        emit_d          = '0;
        ins_en          = 1'b0;
        rem_en          = 1'b0;
        rem_pos         = '0;
        case (state_reg)
            S_IDLE: begin
                if (cmd.valid && out_ok) begin
                    cmd_pop = 1'b1;
                    case (pspa_op_t'(it.operation))
                        OP_ACQUIRE: begin
                            emit                 = 1'b1;
                            emit_d.requester_out = it.requester;
                            emit_d.busy_count    = 4'(bcnt_reg);
                            emit_d.waiting_count = 5'(len_reg);
                            emit_d.last          = 1'b1;
                            if (shut_reg) begin
                                emit_d.status = ST_REFUSED;
                            end else if (len_reg == '0 && free_found) begin
                                busy_next[free_idx]  = 1'b1;
                                bcnt_next            = bcnt_reg + BUSY_W'(1);
                                emit_d.status        = ST_GRANTED;
                                emit_d.slot_out      = 4'(free_idx);
                                emit_d.busy_count    = 4'(bcnt_next);
                            end else if (it.timeout_ticks == 16'd0) begin
                                emit_d.status = ST_TIMED_OUT;
                            end else if (32'(len_reg) >= QUEUE_DEPTH) begin
                                emit_d.status = ST_FULL;
                            end else begin
                                ins_en               = 1'b1;
                                len_next             = len_reg + QLEN_W'(1);
                                emit_d.status        = ST_QUEUED;
                                emit_d.waiting_count = 5'(len_next);
                            end
                        end
                        OP_RELEASE: begin
                            emit                 = 1'b1;
                            emit_d.slot_out      = it.slot;
                            emit_d.busy_count    = 4'(bcnt_reg);
                            emit_d.waiting_count = 5'(len_reg);
                            emit_d.last          = 1'b1;
                            if (!slot_ok) begin
                                emit_d.status = ST_BAD_REL;
                            end else if (len_reg != '0 && slot_live) begin
                                rem_en               = 1'b1;
                                len_next             = len_reg - QLEN_W'(1);
                                emit_d.status        = ST_GRANTED;
                                emit_d.requester_out = wq_reg[0].req;
                                emit_d.waiting_count = 5'(len_next);
                            end else begin
                                busy_next[it.slot[SIDX_W-1:0]] = 1'b0;
                                bcnt_next         = bcnt_reg - BUSY_W'(1);
                                emit_d.status     = ST_RELEASED;
                                emit_d.busy_count = 4'(bcnt_next);
                            end
                        end
                        OP_TICK: begin
                            tick_next       = tick_reg + 32'd1;
                            scan_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = S_SCAN;
                        end
                        default: begin
                            shut_next  = 1'b1;
                            state_next = S_DRAIN;
                        end
                    endcase
                end
            end
            // Walk the queue; hold one expiry back to mark the final one
            S_SCAN: begin
                if (scan_reg < len_reg) begin
                    if (!age[31]) begin
                        if (!pend_valid_reg || out_ok) begin
                            if (pend_valid_reg) begin
                                emit   = 1'b1;
                                emit_d = pend_reg;
                            end
                            rem_en                  = 1'b1;
                            rem_pos                 = scan_reg;
                            len_next                = len_reg - QLEN_W'(1);
                            pend_valid_next         = 1'b1;
                            pend_next               = '0;
                            pend_next.status        = ST_TIMED_OUT;
                            pend_next.requester_out = scan_w.req;
                            pend_next.busy_count    = 4'(bcnt_reg);
                            pend_next.waiting_count = 5'(len_next);
                        end
                    end else begin
                        scan_next = scan_reg + QLEN_W'(1);
                    end
                end else if (!pend_valid_reg) begin
                    state_next = S_IDLE;
                end else if (out_ok) begin
                    emit            = 1'b1;
                    emit_d          = pend_reg;
                    emit_d.last     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            // Refuse every waiter, then acknowledge
            S_DRAIN: begin
                if (out_ok) begin
                    emit              = 1'b1;
                    emit_d.status     = ST_REFUSED;
                    emit_d.busy_count = 4'(bcnt_reg);
                    if (len_reg != '0) begin
                        rem_en               = 1'b1;
                        len_next             = len_reg - QLEN_W'(1);
                        emit_d.requester_out = wq_reg[0].req;
                        emit_d.waiting_count = 5'(len_next);
                    end else begin
                        emit_d.last = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        m_valid_next = emit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
        m_data_next  = emit ? emit_d : m_data_reg;
    end

    // Shift the sorted queue for insert or removal
    always_comb begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            wq_next[j] = wq_reg[j];
        end
        if (ins_en) begin
            for (int j = 1; j < QUEUE_DEPTH; j++) begin
                if (j > int'(ins_pos) && j <= int'(len_reg)) begin
                    wq_next[j] = wq_reg[j-1];
                end
            end
            wq_next[ins_pos[QIDX_W-1:0]] = ins_w;
        end else if (rem_en) begin
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
                if (j >= int'(rem_pos) && j + 1 < int'(len_reg)) begin
                    wq_next[j] = wq_reg[j+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            scan_reg       <= '0;
            len_reg        <= '0;
            busy_reg       <= '0;
            bcnt_reg       <= '0;
            tick_reg       <= '0;
            shut_reg       <= 1'b0;
            mask_reg       <= '1;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_reg       <= scan_next;
            len_reg        <= len_next;
            busy_reg       <= busy_next;
            bcnt_reg       <= bcnt_next;
            tick_reg       <= tick_next;
            shut_reg       <= shut_next;
            mask_reg       <= mask_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            wq_reg[j] <= wq_next[j];
        end
    end

endmodule

// ===== hw/rtl/priority_slot_pool_allocator.sv =====
`timescale 1ns / 1ps
// Slot pool allocator with a priority wait queue.
// Input channel s_valid/s_ready/s_data carries acquire, release, tick and
// shutdown commands; result channel m_valid/m_ready/m_data returns the
// results of each command, the final one flagged by last; a tick that expires no waiter returns none.
// cfg_we/cfg_wdata write the slot valid mask; the user must do so only
// while idle, which the block does not enforce. A two-entry command queue
// decouples the input from the engine, so up to two commands are taken
// while the engine or the output is stalled. Acquire and release: one
// result, through the command queue and the output register; one command
// per cycle while the output drains. Tick: the expiry scan walks the
// queue one entry per cycle while the output is not stalled.
// Shutdown: the engine decodes it, refuses each waiter, then acknowledges.
// A stalled receiver holds the output register and stalls the engine
// wherever it has a result to send.
// Reset clears all slots, the wait queue, the command queue, the tick counter
// and shutdown, and sets the valid mask to all ones; outside reset, no commands are lost once accepted.
module priority_slot_pool_allocator import pspa_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [MASK_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  pspa_in_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pspa_out_t         m_data
);

    pspa_cmd_t cmd;
    logic      cmd_pop;

    pspa_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .cmd     (cmd),
        .cmd_pop (cmd_pop)
    );

    pspa_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== hw/rtl/pspa_checker.sv =====
`timescale 1ns / 1ps
module pspa_checker import pspa_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input pspa_out_t m_data
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status <= ST_BAD_REL)
        else $error("undefined status");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.busy_count) <= NUM_SLOTS)
        else $error("busy count beyond slot count");

    a_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_data.waiting_count) <= QUEUE_DEPTH)
        else $error("waiting count beyond queue depth");

    a_queued: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_QUEUED |-> m_data.waiting_count != 5'd0)
        else $error("queued result with empty queue");

endmodule

bind priority_slot_pool_allocator pspa_checker u_pspa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/sv/tb_priority_slot_pool_allocator.sv =====
`timescale 1ns / 1ps
module tb_priority_slot_pool_allocator import pspa_pkg::*;;

    // Pool state as the testbench tracks it
    class pool_scoreboard;
        logic [7:0]   valid_mask;
        bit           slot_taken[NUM_SLOTS];
        int unsigned  slots_in_use;
        pspa_waiter_t waiters[$];
        logic [31:0]  now_ticks;
        bit           closed;
        pspa_out_t    pending[$];
        int           errors;

        function void clear();
            valid_mask = '1;
            foreach (slot_taken[i]) slot_taken[i] = 0;
            slots_in_use = 0;
            waiters.delete();
            now_ticks = 0;
            closed = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void push_result(pspa_status_t st, logic [7:0] who, logic [3:0] sl);
            pspa_out_t r;
            r.status = st;
            r.requester_out = who;
            r.slot_out = sl;
            r.busy_count = 4'(slots_in_use);
            r.waiting_count = 5'(waiters.size());
            r.last = 0;
            pending.insert(pending.size(), r);
        endfunction

        // Note an accepted command and queue the results it causes
        function void note_command(pspa_in_t c);
            int first_free;
            int base;
            int pos;
            int i;
            pspa_waiter_t w;
            base = pending.size();
            case (pspa_op_t'(c.operation))
                OP_ACQUIRE: begin
                    first_free = -1;
                    for (i = 0; i < NUM_SLOTS; i++)
                        if (first_free < 0 && !slot_taken[i] && valid_mask[i]) first_free = i;
                    if (closed) begin
                        push_result(ST_REFUSED, c.requester, '0);
                    end else if (waiters.size() == 0 && first_free >= 0) begin
                        slot_taken[first_free] = 1;
                        slots_in_use++;
                        push_result(ST_GRANTED, c.requester, 4'(first_free));
                    end else if (c.timeout_ticks == 16'd0) begin
                        push_result(ST_TIMED_OUT, c.requester, '0);
                    end else if (waiters.size() >= QUEUE_DEPTH) begin
                        push_result(ST_FULL, c.requester, '0);
                    end else begin
                        w.prio = c.priority_req;
                        w.req = c.requester;
                        w.deadline = now_ticks + 32'(c.timeout_ticks);
                        pos = 0;
                        while (pos < waiters.size() && waiters[pos].prio <= w.prio) pos++;
                        waiters.insert(pos, w);
                        push_result(ST_QUEUED, c.requester, '0);
                    end
                end
                OP_RELEASE: begin
                    if (c.slot >= NUM_SLOTS || !slot_taken[c.slot]) begin
                        push_result(ST_BAD_REL, '0, c.slot);
                    end else if (waiters.size() > 0 && valid_mask[c.slot]) begin
                        w = waiters[0];
                        waiters.delete(0);
                        push_result(ST_GRANTED, w.req, c.slot);
                    end else begin
                        slot_taken[c.slot] = 0;
                        slots_in_use--;
                        push_result(ST_RELEASED, '0, c.slot);
                    end
                end
                OP_TICK: begin
                    now_ticks++;
                    i = 0;
                    while (i < waiters.size()) begin
                        if ((now_ticks - waiters[i].deadline) < 32'h8000_0000) begin
                            w = waiters[i];
                            waiters.delete(i);
                            push_result(ST_TIMED_OUT, w.req, '0);
                        end else begin
                            i++;
                        end
                    end
                end
                default: begin
                    closed = 1;
                    while (waiters.size() > 0) begin
                        w = waiters[0];
                        waiters.delete(0);
                        push_result(ST_REFUSED, w.req, '0);
                    end
                    push_result(ST_REFUSED, '0, '0);
                end
            endcase
            if (pending.size() > base) pending[pending.size() - 1].last = 1;
        endfunction

        task report_mismatch(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        // Compare one result with the oldest expectation
        task check_result(pspa_out_t got);
            pspa_out_t exp_r;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            exp_r = pending[0];
            pending.delete(0);
            if (got.status !== exp_r.status)
                report_mismatch($sformatf("status %0d exp %0d", got.status, exp_r.status));
            if (got.requester_out !== exp_r.requester_out)
                report_mismatch($sformatf("requester %0d exp %0d",
                                          got.requester_out, exp_r.requester_out));
            if (got.slot_out !== exp_r.slot_out)
                report_mismatch($sformatf("slot %0d exp %0d", got.slot_out, exp_r.slot_out));
            if (got.busy_count !== exp_r.busy_count)
                report_mismatch($sformatf("busy %0d exp %0d",
                                          got.busy_count, exp_r.busy_count));
            if (got.waiting_count !== exp_r.waiting_count)
                report_mismatch($sformatf("waiting %0d exp %0d",
                                          got.waiting_count, exp_r.waiting_count));
            if (got.last !== exp_r.last)
                report_mismatch($sformatf("last %0d exp %0d", got.last, exp_r.last));
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [MASK_W-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    pspa_in_t          s_data;
    logic              m_valid;
    logic              m_ready;
    pspa_out_t         m_data;

    pool_scoreboard pool;
    bit  calm_phase;
    bit  hold_off;
    bit  stim_done;
    int  taken_items;

    priority_slot_pool_allocator u_top (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Check every result transfer and note every command transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) pool.check_result(m_data);
            if (s_valid && s_ready) begin
                pool.note_command(s_data);
                taken_items++;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request
    initial begin
        int n;
        m_ready = 0;
        @(posedge aclk);
        while (!stim_done) begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (60) @(posedge aclk);
                hold_off = 0;
            end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
                m_ready <= 0;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end
        end
        m_ready <= 1;
    end

    // Offer one command and hold it until transferred; valid stays up for
    // a back-to-back follower
    task automatic send_cmd(pspa_op_t op, logic [3:0] pr, logic [7:0] who,
                            logic [3:0] sl, logic [15:0] tmo);
        int gap;
        pspa_in_t c;
        if (!calm_phase && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
        end
        c.operation = op;
        c.priority_req = pr;
        c.requester = who;
        c.slot = sl;
        c.timeout_ticks = tmo;
        s_valid <= 1;
        s_data <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45)
            send_cmd(OP_ACQUIRE, 4'($urandom), 8'($urandom), 4'($urandom),
                     ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                     16'($urandom_range(0, 6)));
        else if (k < 80)
            send_cmd(OP_RELEASE, 4'($urandom), 8'($urandom),
                     ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7)),
                     16'($urandom));
        else if (k < 98)
            send_cmd(OP_TICK, 4'($urandom), 8'($urandom), 4'($urandom), 16'($urandom));
        else
            send_cmd(OP_SHUTDOWN, 4'($urandom), 8'($urandom), 4'($urandom), 16'($urandom));
    endtask

    // Drop the input, let results drain, then write the mask
    task automatic write_mask(logic [7:0] m);
        s_valid <= 0;
        @(posedge aclk);
        while (pool.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we <= 0;
        pool.valid_mask = m;
    endtask

    task automatic pulse_reset_free();
        // Release every slot so later phases start with all slots free
        int i;
        for (i = 0; i < NUM_SLOTS; i++)
            send_cmd(OP_RELEASE, '0, '0, 4'(i), '0);
    endtask

    initial begin
        int i;
        int ph;
        logic [7:0] masks[4];
        pool = new();
        pool.clear();
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_valid = 0;
        s_data = '0;
        calm_phase = 0;
        hold_off = 0;
        stim_done = 0;
        taken_items = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: fill, priority queueing, zero timeout, full queue, shutdown
        write_mask(8'h00);
        send_cmd(OP_ACQUIRE, 4'hF, 8'hFF, '0, 16'd0);
        write_mask(8'hFF);
        for (i = 0; i < 8; i++) send_cmd(OP_ACQUIRE, '0, 8'(i), '0, 16'hFFFF);
        send_cmd(OP_ACQUIRE, 4'd5, 8'h10, '0, 16'd0);
        send_cmd(OP_ACQUIRE, 4'd9, 8'h11, '0, 16'd2);
        send_cmd(OP_ACQUIRE, 4'd0, 8'h12, '0, 16'hFFFF);
        send_cmd(OP_ACQUIRE, 4'd9, 8'h13, '0, 16'd1);
        send_cmd(OP_TICK, '0, '0, '0, '0);
        send_cmd(OP_TICK, '0, '0, '0, '0);
        send_cmd(OP_RELEASE, '0, '0, 4'd3, '0);
        send_cmd(OP_RELEASE, '0, '0, 4'd15, '0);
        send_cmd(OP_RELEASE, '0, '0, 4'd8, '0);
        for (i = 0; i < 17; i++) send_cmd(OP_ACQUIRE, 4'(i), 8'(i + 32), '0, 16'd9);
        send_cmd(OP_SHUTDOWN, '0, '0, '0, '0);
        send_cmd(OP_SHUTDOWN, '0, '0, '0, '0);
        send_cmd(OP_ACQUIRE, '0, 8'h55, '0, 16'd1);
        pulse_reset_free();

        // Random phases under several masks; the earlier shutdown stays in force
        masks[0] = 8'hFF; masks[1] = 8'h81; masks[2] = 8'h3C; masks[3] = 8'hFF;
        for (ph = 0; ph < 4; ph++) begin
            write_mask(masks[ph]);
            if (ph == 3) calm_phase = 1;
            if (ph == 1) hold_off = 1;
            for (i = 0; i < 45; i++) send_random();
        end
        s_valid <= 0;
        stim_done = 1;
        @(posedge aclk);
        while (pool.pending.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (pool.errors == 0)
            $display("** priority_slot_pool_allocator: PASSED **");
        else
            $display("** priority_slot_pool_allocator: FAILED **");
        $finish;
    end

    initial begin
        #2000000;
        $display("** priority_slot_pool_allocator: FAILED **");
        $finish;
    end
endmodule
